@@ rtl/scms_pkg.sv @@
package scms_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_FIRST   = 3'd1,
    MODE_WAIT    = 3'd2,
    MODE_RETURN  = 3'd3,
    MODE_STOPPED = 3'd4,
    MODE_SLOW    = 3'd5,
    MODE_HORN    = 3'd6
  } mode_t;

  localparam logic [1:0] MOT_NONE = 2'd0;
  localparam logic [1:0] MOT_FWD  = 2'd1;
  localparam logic [1:0] MOT_STOP = 2'd2;
  localparam logic [1:0] LIT_NONE = 2'd0;
  localparam logic [1:0] LIT_FWD  = 2'd1;
  localparam logic [1:0] LIT_STOP = 2'd2;
  localparam logic [1:0] BZ_NONE  = 2'd0;
  localparam logic [1:0] BZ_ON    = 2'd1;
  localparam logic [1:0] BZ_OFF   = 2'd2;

  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_W     = 8'h57;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam int unsigned CFG_AW = 4;

  localparam logic [1:0] REG_HORN_TICKS    = 2'd0;
  localparam logic [1:0] REG_WAIT_TICKS    = 2'd1;
  localparam logic [1:0] REG_NORMAL_SPEED  = 2'd2;
  localparam logic [1:0] REG_REDUCED_SPEED = 2'd3;

  localparam logic [15:0] HORN_TICKS_RST    = 16'd500;
  localparam logic [15:0] WAIT_TICKS_RST    = 16'd1000;
  localparam logic [15:0] NORMAL_SPEED_RST  = 16'd600;
  localparam logic [15:0] REDUCED_SPEED_RST = 16'd300;

  typedef struct packed {
    logic [15:0] horn_ticks;
    logic [15:0] wait_ticks;
    logic [15:0] normal_speed;
    logic [15:0] reduced_speed;
  } cfg_t;

  typedef struct packed {
    logic       lane_change_done;
    logic       sign_valid;
    logic [7:0] sign_first_char;
    logic [7:0] sign_second_char;
  } in_item_t;

  typedef struct packed {
    logic        trigger_lane_change;
    logic        lane_direction;
    logic [1:0]  motor_command;
    logic [15:0] motor_speed;
    logic [1:0]  light_command;
    logic [1:0]  buzzer_command;
    logic [2:0]  mode_code;
    logic [7:0]  last_first_char;
    logic [7:0]  last_second_char;
    logic        busy_flag;
    logic        settled_flag;
  } out_item_t;

endpackage

@@ rtl/scms_in_if.sv @@
interface scms_in_if;
  logic       valid;
  logic       ready;
  logic       lane_change_done;
  logic       sign_valid;
  logic [7:0] sign_first_char;
  logic [7:0] sign_second_char;

  modport source (
    output valid, lane_change_done, sign_valid, sign_first_char, sign_second_char,
    input  ready
  );
  modport sink (
    input  valid, lane_change_done, sign_valid, sign_first_char, sign_second_char,
    output ready
  );
endinterface

@@ rtl/scms_out_if.sv @@
interface scms_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_lane_change;
  logic        lane_direction;
  logic [1:0]  motor_command;
  logic [15:0] motor_speed;
  logic [1:0]  light_command;
  logic [1:0]  buzzer_command;
  logic [2:0]  mode_code;
  logic [7:0]  last_first_char;
  logic [7:0]  last_second_char;
  logic        busy_flag;
  logic        settled_flag;

  modport source (
    output valid, trigger_lane_change, lane_direction, motor_command, motor_speed,
           light_command, buzzer_command, mode_code, last_first_char,
           last_second_char, busy_flag, settled_flag,
    input  ready
  );
  modport sink (
    input  valid, trigger_lane_change, lane_direction, motor_command, motor_speed,
           light_command, buzzer_command, mode_code, last_first_char,
           last_second_char, busy_flag, settled_flag,
    output ready
  );
endinterface

@@ rtl/sign_command_maneuver_sequencer.sv @@
// Path: an accepted input transaction is held in the input register, then its
// result moves into the result register, from which the result transaction is
// offered on out_ch.
// Throughput: one transaction per cycle unless out_ch stalls; the mode state
// is updated in the same cycle that a tick moves into the result register.
// Reset (rst_n, synchronous, active low): mode idle, timers zero, last sign
// "-", configuration registers at their default values, both stages empty.
module sign_command_maneuver_sequencer
  import scms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  scms_in_if.sink           in_ch,
  scms_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_v_r;
  out_item_t result;
  out_item_t out_item_r;
  logic      out_v_r;
  logic      advance;
  logic      fire;

  scms_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scms_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // The result register frees up whenever it is empty or being drained; while a
  // result waits, the input stage takes a new transaction only if it is empty.
  assign advance     = !out_v_r || out_ch.ready;
  assign fire        = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.lane_change_done <= in_ch.lane_change_done;
      in_item_r.sign_valid       <= in_ch.sign_valid;
      in_item_r.sign_first_char  <= in_ch.sign_first_char;
      in_item_r.sign_second_char <= in_ch.sign_second_char;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid               = out_v_r;
  assign out_ch.trigger_lane_change = out_item_r.trigger_lane_change;
  assign out_ch.lane_direction      = out_item_r.lane_direction;
  assign out_ch.motor_command       = out_item_r.motor_command;
  assign out_ch.motor_speed         = out_item_r.motor_speed;
  assign out_ch.light_command       = out_item_r.light_command;
  assign out_ch.buzzer_command      = out_item_r.buzzer_command;
  assign out_ch.mode_code           = out_item_r.mode_code;
  assign out_ch.last_first_char     = out_item_r.last_first_char;
  assign out_ch.last_second_char    = out_item_r.last_second_char;
  assign out_ch.busy_flag           = out_item_r.busy_flag;
  assign out_ch.settled_flag        = out_item_r.settled_flag;

endmodule

@@ rtl/scms_cfg_regs.sv @@
module scms_cfg_regs
  import scms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.horn_ticks    <= HORN_TICKS_RST;
      cfg_r.wait_ticks    <= WAIT_TICKS_RST;
      cfg_r.normal_speed  <= NORMAL_SPEED_RST;
      cfg_r.reduced_speed <= REDUCED_SPEED_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HORN_TICKS:    cfg_r.horn_ticks    <= pwdata[15:0];
        REG_WAIT_TICKS:    cfg_r.wait_ticks    <= pwdata[15:0];
        REG_NORMAL_SPEED:  cfg_r.normal_speed  <= pwdata[15:0];
        REG_REDUCED_SPEED: cfg_r.reduced_speed <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HORN_TICKS:    prdata = {16'd0, cfg_r.horn_ticks};
      REG_WAIT_TICKS:    prdata = {16'd0, cfg_r.wait_ticks};
      REG_NORMAL_SPEED:  prdata = {16'd0, cfg_r.normal_speed};
      REG_REDUCED_SPEED: prdata = {16'd0, cfg_r.reduced_speed};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/scms_step.sv @@
module scms_step
  import scms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  mode_t       mode_r, mode_nxt;
  logic        first_dir_r, first_dir_nxt;
  logic [15:0] wait_cnt_r, wait_cnt_nxt;
  logic [15:0] horn_cnt_r, horn_cnt_nxt;
  logic [7:0]  last_c0_r, last_c0_nxt;
  logic [7:0]  last_c1_r, last_c1_nxt;

  always_comb begin
    logic        trig, dir;
    logic [1:0]  mot, lit, bz;
    logic [15:0] spd;
    mode_t       m;

    trig = 1'b0;
    dir  = DIR_LEFT;
    mot  = MOT_NONE;
    lit  = LIT_NONE;
    bz   = BZ_NONE;
    spd  = 16'd0;
    m    = mode_r;
    first_dir_nxt = first_dir_r;
    wait_cnt_nxt  = wait_cnt_r;
    horn_cnt_nxt  = horn_cnt_r;
    last_c0_nxt   = last_c0_r;
    last_c1_nxt   = last_c1_r;

    // The horn timeout runs ahead of the mode step, so a horn that ends
    // leaves the tick in idle, where a sign can still be taken.
    if (m == MODE_HORN) begin
      horn_cnt_nxt = horn_cnt_r + 16'd1;
      if (horn_cnt_nxt >= cfg.horn_ticks) begin
        bz  = BZ_OFF;
        mot = MOT_FWD;
        spd = cfg.normal_speed;
        lit = LIT_FWD;
        m   = MODE_IDLE;
      end
    end

    case (m)
      MODE_FIRST: begin
        if (item.lane_change_done) begin
          mot = MOT_FWD;
          spd = cfg.normal_speed;
          lit = LIT_FWD;
          bz  = BZ_OFF;
          wait_cnt_nxt = 16'd0;
          m   = MODE_WAIT;
        end
      end
      MODE_WAIT: begin
        wait_cnt_nxt = wait_cnt_r + 16'd1;
        if (wait_cnt_nxt >= cfg.wait_ticks) begin
          trig = 1'b1;
          dir  = ~first_dir_r;
          m    = MODE_RETURN;
        end
      end
      MODE_RETURN: begin
        if (item.lane_change_done) begin
          mot = MOT_FWD;
          spd = cfg.normal_speed;
          lit = LIT_FWD;
          bz  = BZ_OFF;
          m   = MODE_IDLE;
        end
      end
      default: ;
    endcase

    if (item.sign_valid && (m inside {MODE_IDLE, MODE_STOPPED, MODE_SLOW})) begin
      if (item.sign_first_char == CHAR_L || item.sign_first_char == CHAR_R) begin
        last_c0_nxt   = item.sign_first_char;
        last_c1_nxt   = CHAR_NUL;
        first_dir_nxt = (item.sign_first_char == CHAR_R) ? DIR_RIGHT : DIR_LEFT;
        trig = 1'b1;
        dir  = first_dir_nxt;
        m    = MODE_FIRST;
      end else if (item.sign_first_char == CHAR_P &&
                   (item.sign_second_char == CHAR_ONE ||
                    item.sign_second_char == CHAR_TWO)) begin
        last_c0_nxt = item.sign_first_char;
        last_c1_nxt = item.sign_second_char;
        mot = MOT_STOP;
        spd = 16'd0;
        lit = LIT_STOP;
        bz  = BZ_ON;
        m   = MODE_STOPPED;
      end else if (item.sign_first_char == CHAR_H) begin
        last_c0_nxt  = item.sign_first_char;
        last_c1_nxt  = CHAR_NUL;
        bz           = BZ_ON;
        horn_cnt_nxt = 16'd0;
        m            = MODE_HORN;
      end else if (item.sign_first_char == CHAR_W) begin
        last_c0_nxt = item.sign_first_char;
        last_c1_nxt = CHAR_NUL;
        mot = MOT_FWD;
        spd = cfg.reduced_speed;
        lit = LIT_FWD;
        m   = MODE_SLOW;
      end else if (item.sign_first_char == CHAR_F) begin
        last_c0_nxt = item.sign_first_char;
        last_c1_nxt = CHAR_NUL;
        mot = MOT_FWD;
        spd = cfg.normal_speed;
        lit = LIT_FWD;
        bz  = BZ_OFF;
        m   = MODE_IDLE;
      end
    end

    mode_nxt = m;

    result.trigger_lane_change = trig;
    result.lane_direction      = trig & dir;
    result.motor_command       = mot;
    result.motor_speed         = (mot == MOT_FWD) ? spd : 16'd0;
    result.light_command       = lit;
    result.buzzer_command      = bz;
    result.mode_code           = m;
    result.last_first_char     = last_c0_nxt;
    result.last_second_char    = last_c1_nxt;
    result.busy_flag           = !(m inside {MODE_IDLE, MODE_STOPPED});
    result.settled_flag        = m inside {MODE_IDLE, MODE_STOPPED, MODE_SLOW};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      first_dir_r <= DIR_LEFT;
      wait_cnt_r  <= 16'd0;
      horn_cnt_r  <= 16'd0;
      last_c0_r   <= CHAR_DASH;
      last_c1_r   <= CHAR_NUL;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      first_dir_r <= first_dir_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      horn_cnt_r  <= horn_cnt_nxt;
      last_c0_r   <= last_c0_nxt;
      last_c1_r   <= last_c1_nxt;
    end
  end

endmodule
